// ===== design/mi3_pkg.sv =====
// shared constants, types and helpers for the 3x3 matrix inverse
package mi3_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int CM_BITS   = PROD_BITS;
    localparam int DET_BITS  = PROD_BITS + WORD_BITS + 2;
    localparam int NUM_BITS  = CM_BITS + 2 * FRAC_BITS;
    localparam int QUO_BITS  = NUM_BITS;
    localparam int QCNT_BITS = $clog2(QUO_BITS + 1);
    localparam int N_ELEM    = 9;
    localparam int IDX_BITS  = 4;
    localparam int QDEPTH    = 2;

    typedef enum logic [2:0] {
        BK_IDLE, BK_MUL, BK_COF, BK_DET, BK_DIV, BK_OUT
    } bk_state_t;

    typedef struct packed {
        logic [N_ELEM*WORD_BITS-1:0] mat;
    } job_t;

    function automatic logic [3:0] cof_idx(input logic [3:0] r, input logic [3:0] c);
        return 4'(r * 3 + c);
    endfunction
endpackage

// ===== design/matrix3x3_inverse.sv =====
// top level of the 3x3 matrix inverse
// Elements load one per cycle while busy is low; busy rises only while the two-entry
// job queue is full. A last element queues a run: the back end forms each cofactor from
// two products taken in turn and subtracted, then accumulates the determinant, then
// runs each result through the one-bit-a-cycle divider and emits it; a singular run
// skips the divider and emits its nine results back to back. Results come one strobe
// each; the receiver cannot stall them.
module matrix3x3_inverse (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mi3_pkg::IDX_BITS-1:0] element_index,
    input  logic signed [31:0]           element_value,
    input  logic                         last_element,
    output logic                         result_valid,
    output logic [mi3_pkg::IDX_BITS-1:0] result_index,
    output logic signed [31:0]           result_value,
    output logic                         is_singular,
    output logic                         saturated,
    output logic                         final_result
);
    logic          q_push, q_pop, q_full, q_empty;
    mi3_pkg::job_t q_data, q_head;

    mi3_front u_front (
        .clk, .rst_n, .start, .element_index, .element_value, .last_element,
        .q_full, .busy, .q_push, .q_data
    );

    mi3_queue u_queue (
        .clk, .rst_n, .push(q_push), .push_data(q_data), .pop(q_pop),
        .full(q_full), .empty(q_empty), .head(q_head)
    );

    mi3_back u_back (
        .clk, .rst_n, .q_empty, .q_head, .q_pop, .result_valid, .result_index,
        .result_value, .is_singular, .saturated, .final_result
    );
endmodule

// ===== design/mi3_front.sv =====
// front end: element store and job issue into the queue
module mi3_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mi3_pkg::IDX_BITS-1:0]   element_index,
    input  logic signed [31:0]             element_value,
    input  logic                           last_element,
    input  logic                           q_full,
    output logic                           busy,
    output logic                           q_push,
    output mi3_pkg::job_t                  q_data
);
    logic [mi3_pkg::WORD_BITS-1:0] store_reg [mi3_pkg::N_ELEM];
    logic                          acc;

    assign busy = q_full;
    assign acc  = start && !busy;
    assign q_push = acc && last_element;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mi3_pkg::N_ELEM; i++)
                store_reg[i] <= '0;
        end
        else if (acc && element_index < 4'(mi3_pkg::N_ELEM))
        begin
            store_reg[element_index] <= element_value[mi3_pkg::WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < mi3_pkg::N_ELEM; i++)
        begin
            if (acc && element_index == 4'(i))
                q_data.mat[i*mi3_pkg::WORD_BITS +: mi3_pkg::WORD_BITS] =
                    element_value[mi3_pkg::WORD_BITS-1:0];
            else
                q_data.mat[i*mi3_pkg::WORD_BITS +: mi3_pkg::WORD_BITS] = store_reg[i];
        end
    end
endmodule

// ===== design/mi3_queue.sv =====
// two-entry job queue between front and back
module mi3_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mi3_pkg::job_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output mi3_pkg::job_t head
);
    mi3_pkg::job_t mem_reg [mi3_pkg::QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'(mi3_pkg::QDEPTH);
    assign empty = cnt_reg == 2'd0;
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== design/mi3_back.sv =====
// back end: cofactors, determinant, serial divide and result issue
module mi3_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  mi3_pkg::job_t                q_head,
    output logic                         q_pop,
    output logic                         result_valid,
    output logic [mi3_pkg::IDX_BITS-1:0] result_index,
    output logic signed [31:0]           result_value,
    output logic                         is_singular,
    output logic                         saturated,
    output logic                         final_result
);
    localparam int W  = mi3_pkg::WORD_BITS;
    localparam int PB = mi3_pkg::PROD_BITS;
    localparam int DB = mi3_pkg::DET_BITS;
    localparam int NB = mi3_pkg::NUM_BITS;

    mi3_pkg::bk_state_t state_reg, state_next;
    logic signed [W-1:0]  m_reg [mi3_pkg::N_ELEM];
    logic [3:0]           k_reg, k_next;
    logic                 ph_reg;
    logic signed [PB-1:0] p_reg, q_reg;
    logic signed [PB:0]   cof_reg [mi3_pkg::N_ELEM];
    logic [2:0]           dk_reg;
    logic signed [DB-1:0] det_reg;
    logic signed [DB-1:0] dprod_reg;
    logic [3:0]           dj;
    logic signed [W-1:0]  dm;
    logic signed [W:0]    dop;
    logic signed [2*W:0]  dpart;
    logic [DB-1:0]        dmag;
    logic                 dneg;
    logic [NB-1:0]        num_reg, quo_reg;
    logic [DB:0]          rem_reg;
    logic [mi3_pkg::QCNT_BITS-1:0] bit_reg;
    logic [DB:0]          rem_sh;
    logic [3:0]           r1, r2, c1, c2, rr, cc;
    logic                 cneg;
    logic [PB:0]          cmag;
    logic [NB-1:0]        lim;

    assign dneg = det_reg[DB-1];
    assign dmag = dneg ? DB'(-det_reg) : DB'(det_reg);

    // cofactor (rr, cc) used for result k: cofactor(col, row)
    always_comb
    begin
        cc = (k_reg >= 4'd6) ? 4'd2 : ((k_reg >= 4'd3) ? 4'd1 : 4'd0);
        rr = k_reg - cc * 4'd3;
        r1 = (rr == 4'd2) ? 4'd0 : rr + 4'd1;
        r2 = (rr == 4'd0) ? 4'd2 : rr - 4'd1;
        c1 = (cc == 4'd2) ? 4'd0 : cc + 4'd1;
        c2 = (cc == 4'd0) ? 4'd2 : cc - 4'd1;
    end

    // determinant partial product: m[0,j] times low or high half of cofactor(0,j)
    always_comb
    begin
        dj = 4'(dk_reg[2:1]);
        dm = m_reg[mi3_pkg::cof_idx(4'd0, dj)];
        if (dk_reg[0])
            dop = cof_reg[mi3_pkg::cof_idx(dj, 4'd0)][PB:W];
        else
            dop = signed'({1'b0, cof_reg[mi3_pkg::cof_idx(dj, 4'd0)][W-1:0]});
        dpart = dm * dop;
    end

    assign cneg = cof_reg[k_reg][PB];
    assign cmag = cneg ? -cof_reg[k_reg] : cof_reg[k_reg];
    assign rem_sh = {rem_reg[DB-1:0], num_reg[NB-1]};
    assign lim = (cneg != dneg) ? NB'(64'(1) << (W-1)) : NB'((64'(1) << (W-1)) - 1);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            mi3_pkg::BK_IDLE: if (!q_empty) state_next = mi3_pkg::BK_MUL;
            mi3_pkg::BK_MUL:  if (ph_reg) state_next = mi3_pkg::BK_COF;
            mi3_pkg::BK_COF:
            begin
                if (k_reg == 4'd8)
                begin
                    state_next = mi3_pkg::BK_DET;
                    k_next = 4'd0;
                end
                else
                begin
                    state_next = mi3_pkg::BK_MUL;
                    k_next = k_reg + 4'd1;
                end
            end
            mi3_pkg::BK_DET:
                if (dk_reg == 3'd7)
                    state_next = (det_reg == '0) ? mi3_pkg::BK_OUT : mi3_pkg::BK_DIV;
            mi3_pkg::BK_DIV:
                if (bit_reg == mi3_pkg::QCNT_BITS'(NB)) state_next = mi3_pkg::BK_OUT;
            mi3_pkg::BK_OUT:
            begin
                if (k_reg == 4'd8)
                begin
                    state_next = mi3_pkg::BK_IDLE;
                    k_next = 4'd0;
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                    state_next = (det_reg == '0) ? mi3_pkg::BK_OUT : mi3_pkg::BK_DIV;
                end
            end
            default: state_next = mi3_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop        = state_reg == mi3_pkg::BK_IDLE && !q_empty;
        result_valid = state_reg == mi3_pkg::BK_OUT;
        result_index = k_reg;
        final_result = result_valid && k_reg == 4'd8;
        is_singular  = det_reg == '0;
        saturated    = 1'b0;
        result_value = 32'(signed'(m_reg[k_reg]));
        if (!is_singular)
        begin
            if (quo_reg > lim)
            begin
                saturated    = 1'b1;
                result_value = (cneg != dneg) ? 32'(-(64'(lim))) : 32'(lim);
            end
            else
                result_value = (cneg != dneg) ? 32'(-quo_reg) : 32'(quo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mi3_pkg::BK_IDLE;
            k_reg     <= 4'd0;
            ph_reg    <= 1'b0;
            dk_reg    <= 3'd0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ph_reg    <= (state_reg == mi3_pkg::BK_MUL) ? ~ph_reg : 1'b0;
            dk_reg    <= (state_reg == mi3_pkg::BK_DET) ? dk_reg + 3'd1 : 3'd0;
            if (state_reg == mi3_pkg::BK_DIV)
                bit_reg <= bit_reg + mi3_pkg::QCNT_BITS'(1);
            else
                bit_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int i = 0; i < mi3_pkg::N_ELEM; i++)
                m_reg[i] <= q_head.mat[i*W +: W];
        end
        if (state_reg == mi3_pkg::BK_MUL)
        begin
            if (!ph_reg)
                p_reg <= PB'(m_reg[mi3_pkg::cof_idx(r1, c1)]) * PB'(m_reg[mi3_pkg::cof_idx(r2, c2)]);
            else
                q_reg <= PB'(m_reg[mi3_pkg::cof_idx(r1, c2)]) * PB'(m_reg[mi3_pkg::cof_idx(r2, c1)]);
        end
        if (state_reg == mi3_pkg::BK_COF)
            cof_reg[k_reg] <= (PB+1)'(p_reg) - (PB+1)'(q_reg);
        if (state_reg == mi3_pkg::BK_DET)
        begin
            // det = sum m[0,j] * cofactor(0,j); cofactor(0,j) sits at k = 3j
            // six partial products, each accumulated in the cycle after it is formed
            if (dk_reg == 3'd0)
                det_reg <= '0;
            else if (dk_reg != 3'd7)
                det_reg <= det_reg + dprod_reg;
            if (dk_reg < 3'd6)
                dprod_reg <= dk_reg[0] ? (DB'(dpart) <<< W) : DB'(dpart);
        end
        if ((state_reg == mi3_pkg::BK_DET && dk_reg == 3'd7) ||
            (state_reg == mi3_pkg::BK_OUT && k_reg != 4'd8))
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (state_reg == mi3_pkg::BK_DIV)
        begin
            if (bit_reg == '0)
            begin
                num_reg <= NB'(cmag) << (2 * mi3_pkg::FRAC_BITS);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            else
            begin
                num_reg <= num_reg << 1;
                if (rem_sh >= {1'b0, dmag})
                begin
                    rem_reg <= rem_sh - {1'b0, dmag};
                    quo_reg <= {quo_reg[NB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[NB-2:0], 1'b0};
                end
            end
        end
    end
endmodule
